@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pem_pkg.sv @@
package pem_pkg;

	// Fixed-point formats of the exponential datapath
	localparam int RATE_W   = 24;
	localparam int N_W      = 6;
	localparam int Z_W      = 32;
	localparam int TERM_W   = 33;
	localparam int SUM_W    = 34;
	localparam int E_W      = 36;
	localparam int Y_W      = 37;
	localparam int U_W      = 62;
	localparam int PLOW_W   = 29;
	localparam int M_W      = 33;
	localparam int TERMS    = 14;

	localparam logic [32:0]       LOG2E_Q32 = 33'd6196328019;
	localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
	localparam logic [PLOW_W-1:0] T_LIMIT   = 29'd402653184;
	localparam logic [N_W-1:0]    N_HUGE    = 6'd34;
	localparam logic [TERM_W-1:0] ONE_TERM  = 33'h1_0000_0000;
	localparam logic [SUM_W-1:0]  ONE_SUM   = 34'h1_0000_0000;

	typedef enum logic [1:0] {
		REG_MIN  = 2'd0,
		REG_MAX  = 2'd1,
		REG_RATE = 2'd2
	} pem_reg_t;

	// Control carried alongside the datapath in the back end
	typedef struct packed {
		logic           valid;
		logic           below;
		logic           huge;
		logic [N_W-1:0] n;
	} pem_ctl_t;

	// Reciprocal of k: ceil(2^(32+l)/k), l = ceil(log2 k)
	function automatic logic [M_W-1:0] recip_m(input int k);
		logic [M_W-1:0] m;
		begin
			unique case (k)
				1:       m = 33'd4294967296;
				2:       m = 33'd4294967296;
				3:       m = 33'd5726623062;
				4:       m = 33'd4294967296;
				5:       m = 33'd6871947674;
				6:       m = 33'd5726623062;
				7:       m = 33'd4908534053;
				8:       m = 33'd4294967296;
				9:       m = 33'd7635497416;
				10:      m = 33'd6871947674;
				11:      m = 33'd6247225158;
				12:      m = 33'd5726623062;
				13:      m = 33'd5286113596;
				14:      m = 33'd4908534053;
				default: m = 33'd4294967296;
			endcase
			return m;
		end
	endfunction

	// Matching shift: 32 + ceil(log2 k)
	function automatic int recip_s(input int k);
		int s;
		begin
			if (k <= 1)
				s = 32;
			else if (k <= 2)
				s = 33;
			else if (k <= 4)
				s = 34;
			else if (k <= 8)
				s = 35;
			else
				s = 36;
			return s;
		end
	endfunction

endpackage

@@ rtl/pem_fifo.sv @@
module pem_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             rd_fire;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = store_q[rd_ptr_q];
	assign rd_fire = pop && !empty;

	// Store entry on push
	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= wdata;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (rd_fire)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !rd_fire)
				count_q <= count_q + CW'(1);
			else if (!push && rd_fire)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ rtl/pem_front.sv @@
module pem_front #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  full,
	input  logic [PIXEL_BITS-1:0] min_level,
	input  logic                  deq,
	output logic                  q_empty,
	output logic                  q_below,
	output logic [PIXEL_BITS-1:0] q_delta
);

	logic                  below;
	logic [PIXEL_BITS-1:0] delta;
	logic                  accept;
	logic [PIXEL_BITS:0]   q_rdata;

	// Classify: below the range, else offset from the floor
	assign below  = (pixel < min_level);
	assign delta  = below ? '0 : (pixel - min_level);
	assign accept = push && !full;

	pem_fifo #(
		.WIDTH(PIXEL_BITS + 1),
		.DEPTH(4)
	) u_pem_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata ({below, delta}),
		.full  (full),
		.pop   (deq),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign q_below = q_rdata[PIXEL_BITS];
	assign q_delta = q_rdata[PIXEL_BITS-1:0];

endmodule

@@ rtl/pem_term.sv @@
module pem_term #(
	parameter int K = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  pem_pkg::pem_ctl_t             ctl_i,
	input  logic [pem_pkg::Z_W-1:0]       z_i,
	input  logic [pem_pkg::TERM_W-1:0]    term_i,
	input  logic [pem_pkg::SUM_W-1:0]     sum_i,
	output pem_pkg::pem_ctl_t             ctl_o,
	output logic [pem_pkg::Z_W-1:0]       z_o,
	output logic [pem_pkg::TERM_W-1:0]    term_o,
	output logic [pem_pkg::SUM_W-1:0]     sum_o
);

	localparam logic [pem_pkg::M_W-1:0] RECIP = pem_pkg::recip_m(K);
	localparam int                      SHIFT = pem_pkg::recip_s(K);

	logic [64:0] prod_a;
	logic [64:0] prod_b;
	logic [31:0] quot;

	pem_pkg::pem_ctl_t             ctl_s1, ctl_s2;
	logic [pem_pkg::Z_W-1:0]       z_s1, z_s2;
	logic [31:0]                   a_s1;
	logic [pem_pkg::SUM_W-1:0]     sum_s1, sum_s2;
	logic [pem_pkg::TERM_W-1:0]    term_s2;

	// term * z in Q.32
	assign prod_a = 65'(term_i) * 65'(z_i);
	// divide by K through its reciprocal
	assign prod_b = 65'(a_s1) * 65'(RECIP);
	assign quot   = 32'(prod_b >> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= z_i;
			a_s1    <= prod_a[63:32];
			sum_s1  <= sum_i;
			z_s2    <= z_s1;
			term_s2 <= pem_pkg::TERM_W'(quot);
			sum_s2  <= sum_s1 + pem_pkg::SUM_W'(quot);
		end
	end

	assign ctl_o  = ctl_s2;
	assign z_o    = z_s2;
	assign term_o = term_s2;
	assign sum_o  = sum_s2;

endmodule

@@ rtl/pem_back.sv @@
module pem_back #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [PIXEL_BITS-1:0]        min_level,
	input  logic [PIXEL_BITS-1:0]        max_level,
	input  logic [pem_pkg::RATE_W-1:0]   rate,
	input  logic                         q_empty,
	input  logic                         q_below,
	input  logic [PIXEL_BITS-1:0]        q_delta,
	output logic                         deq,
	output logic                         empty,
	input  logic                         pop,
	output logic [PIXEL_BITS-1:0]        mapped,
	output logic                         clipped
);

	localparam int P_W = PIXEL_BITS + pem_pkg::RATE_W;

	logic                  en;
	logic                  out_full;
	logic                  res_push;
	logic [PIXEL_BITS-1:0] res_val;
	logic                  res_clip;
	logic [PIXEL_BITS:0]   out_rdata;

	pem_pkg::pem_ctl_t ctl_b1, ctl_b2, ctl_b3, ctl_f1;
	logic [P_W-1:0]                 p_b1;
	logic [pem_pkg::U_W-1:0]        u_b2;
	logic [pem_pkg::Z_W-1:0]        z_b3;
	logic [pem_pkg::Y_W-1:0]        y_f1;

	logic [pem_pkg::U_W-1:0]        u_prod;
	logic [63:0]                    z_prod;
	logic [pem_pkg::N_W-1:0]        n_w;
	logic [67:0]                    e_ext;
	logic [pem_pkg::E_W-1:0]        e_w;
	logic [PIXEL_BITS-1:0]          min_less;

	pem_pkg::pem_ctl_t              ctl_k  [pem_pkg::TERMS+1];
	logic [pem_pkg::Z_W-1:0]        z_k    [pem_pkg::TERMS+1];
	logic [pem_pkg::TERM_W-1:0]     term_k [pem_pkg::TERMS+1];
	logic [pem_pkg::SUM_W-1:0]      sum_k  [pem_pkg::TERMS+1];

	// Whole pipeline advances while the result queue can take a beat
	assign en       = !out_full || (pop && !empty);
	assign deq      = en && !q_empty;
	assign res_push = en && ctl_f1.valid;

	// Exponent scaled by log2(e), then fraction scaled by ln2
	assign u_prod = pem_pkg::U_W'(p_b1[pem_pkg::PLOW_W-1:0]) *
		pem_pkg::U_W'(pem_pkg::LOG2E_Q32);
	assign n_w    = u_b2[pem_pkg::U_W-1:56];
	assign z_prod = 64'(u_b2[55:24]) * 64'(pem_pkg::LN2_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_b1 <= '0;
			ctl_b2 <= '0;
			ctl_b3 <= '0;
			ctl_f1 <= '0;
		end else if (en) begin
			ctl_b1.valid <= !q_empty;
			ctl_b1.below <= q_below;
			ctl_b1.huge  <= 1'b0;
			ctl_b1.n     <= '0;
			ctl_b2       <= '{valid: ctl_b1.valid, below: ctl_b1.below,
				huge: (p_b1 >= P_W'(pem_pkg::T_LIMIT)), n: ctl_b1.n};
			ctl_b3       <= '{valid: ctl_b2.valid, below: ctl_b2.below,
				huge: ctl_b2.huge || (n_w >= pem_pkg::N_HUGE), n: n_w};
			ctl_f1       <= ctl_k[pem_pkg::TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_b1 <= P_W'(rate) * P_W'(q_delta);
			u_b2 <= u_prod;
			z_b3 <= z_prod[63:32];
			y_f1 <= pem_pkg::Y_W'(e_w) - pem_pkg::Y_W'(1) + pem_pkg::Y_W'(min_level);
		end
	end

	// Power series for 2^frac, one term per two stages
	assign ctl_k[0]  = ctl_b3;
	assign z_k[0]    = z_b3;
	assign term_k[0] = pem_pkg::ONE_TERM;
	assign sum_k[0]  = pem_pkg::ONE_SUM;

	for (genvar k = 1; k <= pem_pkg::TERMS; k++) begin : g_term
		pem_term #(
			.K(k)
		) u_pem_term (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (ctl_k[k-1]),
			.z_i   (z_k[k-1]),
			.term_i(term_k[k-1]),
			.sum_i (sum_k[k-1]),
			.ctl_o (ctl_k[k]),
			.z_o   (z_k[k]),
			.term_o(term_k[k]),
			.sum_o (sum_k[k])
		);
	end

	// Scale mantissa by 2^n and drop the fraction
	assign e_ext = 68'(sum_k[pem_pkg::TERMS]) << ctl_k[pem_pkg::TERMS].n;
	assign e_w   = e_ext[67:32];

	// Clamp to range; ceiling wins if min exceeds max by two or more
	assign min_less = min_level - PIXEL_BITS'(1);
	always_comb begin
		if (ctl_f1.below) begin
			res_val  = (min_less > max_level) ? max_level : min_level;
			res_clip = 1'b1;
		end else if (ctl_f1.huge || (y_f1 > pem_pkg::Y_W'(max_level))) begin
			res_val  = max_level;
			res_clip = 1'b1;
		end else if (y_f1 < pem_pkg::Y_W'(min_level)) begin
			res_val  = min_level;
			res_clip = 1'b1;
		end else begin
			res_val  = y_f1[PIXEL_BITS-1:0];
			res_clip = 1'b0;
		end
	end

	pem_fifo #(
		.WIDTH(PIXEL_BITS + 1),
		.DEPTH(2)
	) u_pem_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata ({res_clip, res_val}),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign clipped = out_rdata[PIXEL_BITS];
	assign mapped  = out_rdata[PIXEL_BITS-1:0];

endmodule

@@ rtl/pixel_exponential_map_top.sv @@
// Exponential grey-level map, one pixel per cycle sustained while results are popped.
// A pixel passes the front command queue, scale stages b1, b2 and b3, the
// fourteen-term power series (two stages per term), stage f1 and the result queue.
// Front command queue of 4 and result queue of 2 let each side stall on its own.
// arst_n clears queues and pipeline valids; min 0, max 65535, rate 2839.
module pixel_exponential_map_top #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            push,
	output logic                                            full,
	input  logic [PIXEL_BITS-1:0]                           pixel,
	output logic                                            empty,
	input  logic                                            pop,
	output logic [PIXEL_BITS-1:0]                           mapped,
	output logic                                            clipped,
	input  logic                                            wr_en,
	input  logic [1:0]                                      wr_index,
	input  logic [((PIXEL_BITS > 24) ? PIXEL_BITS : 24)-1:0] wr_data
);

	logic [PIXEL_BITS-1:0]            min_q;
	logic [PIXEL_BITS-1:0]            max_q;
	logic [pem_pkg::RATE_W-1:0]       rate_q;
	logic                             q_empty;
	logic                             q_below;
	logic [PIXEL_BITS-1:0]            q_delta;
	logic                             deq;

	// Configuration registers; unknown index drops the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= PIXEL_BITS'(32'd65535);
			rate_q <= 24'd2839;
		end else if (wr_en) begin
			unique case (pem_pkg::pem_reg_t'(wr_index))
				pem_pkg::REG_MIN:  min_q  <= wr_data[PIXEL_BITS-1:0];
				pem_pkg::REG_MAX:  max_q  <= wr_data[PIXEL_BITS-1:0];
				pem_pkg::REG_RATE: rate_q <= wr_data[pem_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	pem_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_pem_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pixel    (pixel),
		.full     (full),
		.min_level(min_q),
		.deq      (deq),
		.q_empty  (q_empty),
		.q_below  (q_below),
		.q_delta  (q_delta)
	);

	pem_back #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_pem_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.min_level(min_q),
		.max_level(max_q),
		.rate     (rate_q),
		.q_empty  (q_empty),
		.q_below  (q_below),
		.q_delta  (q_delta),
		.deq      (deq),
		.empty    (empty),
		.pop      (pop),
		.mapped   (mapped),
		.clipped  (clipped)
	);

endmodule

@@ rtl/pem_checker.sv @@
`include "assert_macros.svh"

module pem_checker #(
	parameter int PIXEL_BITS = 16
) (
	input logic                                            clk,
	input logic                                            arst_n,
	input logic                                            push,
	input logic                                            full,
	input logic                                            empty,
	input logic                                            pop,
	input logic [PIXEL_BITS-1:0]                           mapped,
	input logic                                            clipped,
	input logic                                            wr_en,
	input logic [1:0]                                      wr_index,
	input logic [((PIXEL_BITS > 24) ? PIXEL_BITS : 24)-1:0] wr_data
);

	logic [6:0]            cnt_q;
	logic [PIXEL_BITS-1:0] min_q;
	logic [PIXEL_BITS-1:0] max_q;
	logic                  in_beat;
	logic                  out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	// Track pixels in flight and the range as seen on the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= '0;
			max_q <= PIXEL_BITS'(32'd65535);
		end else begin
			if (in_beat && !out_beat)
				cnt_q <= cnt_q + 7'd1;
			else if (!in_beat && out_beat)
				cnt_q <= cnt_q - 7'd1;
			if (wr_en && wr_index == pem_pkg::REG_MIN)
				min_q <= wr_data[PIXEL_BITS-1:0];
			if (wr_en && wr_index == pem_pkg::REG_MAX)
				max_q <= wr_data[PIXEL_BITS-1:0];
		end
	end

	`PEM_ASSERT_NOW(a_no_phantom, clk, arst_n, cnt_q == 7'd0, empty, "result with no pixel pending")
	`PEM_ASSERT_NEXT(a_hold_beat, clk, arst_n, !empty && !pop, !empty, "waiting result dropped")
	`PEM_ASSERT_NEXT(a_hold_data, clk, arst_n, !empty && !pop, $stable(mapped) && $stable(clipped), "waiting result changed")
	`PEM_ASSERT_NOW(a_in_range, clk, arst_n, !empty && !clipped, mapped >= min_q && mapped <= max_q, "unclipped result outside range")

endmodule

bind pixel_exponential_map_top pem_checker #(
	.PIXEL_BITS(PIXEL_BITS)
) u_pem_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.empty   (empty),
	.pop     (pop),
	.mapped  (mapped),
	.clipped (clipped),
	.wr_en   (wr_en),
	.wr_index(wr_index),
	.wr_data (wr_data)
);
